// ===== rtl/max_heap_priority_queue_unit_defines.svh =====
// Assertion macros for the heap queue checker
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mhpq_pkg.sv =====
// Package: field widths, codes and sequencer states of the heap queue
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int KEY_BITS    = 32;
  localparam int COUNT_BITS  = 7;
  localparam int STATUS_BITS = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_ISSUE,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_ISSUE,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   top_key;
    logic                  top_valid;
    logic [COUNT_BITS-1:0] count;
    status_t               status;
  } result_t;

endpackage

// ===== rtl/mhpq_if.sv =====
// Request and response channel interfaces of the heap queue
`timescale 1ns / 1ps

interface mhpq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [mhpq_pkg::KEY_BITS-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface mhpq_out_if;
  logic                             valid;
  logic                             ready;
  logic [mhpq_pkg::KEY_BITS-1:0]    top_key;
  logic                             top_valid;
  logic [mhpq_pkg::COUNT_BITS-1:0]  count;
  logic [mhpq_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, output top_key, output top_valid, output count,
                  output status, input ready);
  modport sink   (input valid, input top_key, input top_valid, input count,
                  input status, output ready);
endinterface

// ===== rtl/max_heap_priority_queue_unit.sv =====
// Binary max-heap priority queue: top level with heap RAM and output register
// Each request walks the heap a level at a time through one heap RAM read port.
// One request at a time: a new request is taken only after the response of the
// last one is loaded into the output register, which frees the sequencer.
// Reset (rst, synchronous) empties the heap; RAM contents are left as they are.
`timescale 1ns / 1ps

module max_heap_priority_queue_unit #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  mhpq_in_if.sink    req,
  mhpq_out_if.source rsp
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic                 res_valid, res_take;
  result_t              res;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [KEY_WIDTH-1:0] mem_wdata, mem_rdata;
  logic                 out_valid;
  result_t              out_res;

  mhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mhpq_sift #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_sift (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Load when the register is empty or its transfer completes this cycle
  assign res_take = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.top_key   = out_res.top_key;
  assign rsp.top_valid = out_res.top_valid;
  assign rsp.count     = out_res.count;
  assign rsp.status    = out_res.status;

endmodule

// ===== rtl/mhpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mhpq_sift.sv =====
// Sift sequencer: one compare unit walks the heap a level at a time
`timescale 1ns / 1ps

module mhpq_sift #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  mhpq_in_if.sink                     req,
  output logic                        res_valid,
  input  logic                        res_take,
  output mhpq_pkg::result_t           res,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [KEY_WIDTH-1:0]        mem_wdata,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  input  logic [KEY_WIDTH-1:0]        mem_rdata
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  state_t               state, state_next;
  logic [AW-1:0]        pos, pos_next;
  logic [KEY_WIDTH-1:0] cur, cur_next;
  logic [KEY_WIDTH-1:0] left, left_next;
  logic [CW-1:0]        count, count_next;
  logic [KEY_WIDTH-1:0] top;
  status_t              status, status_next;

  logic [63:0]          key_ext;
  logic [63:0]          top_ext;
  logic [31:0]          cnt_ext;
  logic [XW-1:0]        lc_ext, rc_ext, cnt_x;
  logic [AW-1:0]        parent;
  logic                 lc_less, rc_less, rc_below_lc;

  assign key_ext = 64'(req.key);
  assign top_ext = 64'(top);
  assign cnt_ext = 32'(count);
  assign lc_ext  = (XW'(pos) << 1) + XW'(1);
  assign rc_ext  = lc_ext + XW'(1);
  assign cnt_x   = XW'(count);
  assign parent  = (pos - AW'(1)) >> 1;

  // Compares: read data against the moving key and the held left child, and the held left child against the moving key
  assign lc_less     = left < cur;
  assign rc_less     = mem_rdata < cur;
  assign rc_below_lc = mem_rdata < left;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      status <= ST_DONE;
    end else begin
      state  <= state_next;
      count  <= count_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    cur  <= cur_next;
    left <= left_next;
    if (mem_we && (mem_waddr == '0)) begin
      top <= mem_wdata;
    end
  end

  always_comb begin
    state_next  = state;
    pos_next    = pos;
    cur_next    = cur;
    left_next   = left;
    count_next  = count;
    status_next = status;
    req.ready   = 1'b0;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pos;
    mem_wdata   = cur;
    mem_raddr   = parent;

    case (state)
      S_IDLE: begin
        req.ready  = 1'b1;
        mem_raddr  = AW'(count - CW'(1));
        if (req.valid) begin
          status_next = ST_DONE;
          if (req.op == OP_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              status_next = ST_FULL;
              state_next  = S_DONE;
            end else begin
              cur_next   = key_ext[KEY_WIDTH-1:0];
              pos_next   = AW'(count);
              count_next = count + CW'(1);
              state_next = S_UP_ISSUE;
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_DONE;
            end else if (count == CW'(1)) begin
              count_next = '0;
              state_next = S_DONE;
            end else begin
              // Read the last entry; it becomes the moving key with the hole at the root
              count_next = count - CW'(1);
              pos_next   = '0;
              state_next = S_DN_LAST;
            end
          end
        end
      end

      S_UP_ISSUE: begin
        if (pos == '0) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_raddr  = parent;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        if (mem_rdata < cur) begin
          // Pull the smaller parent down into the hole and climb
          mem_wdata  = mem_rdata;
          pos_next   = parent;
          state_next = S_UP_ISSUE;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DN_LAST: begin
        cur_next   = mem_rdata;
        state_next = S_DN_ISSUE;
      end

      S_DN_ISSUE: begin
        if (lc_ext >= cnt_x) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_raddr  = lc_ext[AW-1:0];
          state_next = S_DN_LEFT;
        end
      end

      S_DN_LEFT: begin
        left_next = mem_rdata;
        if (rc_ext >= cnt_x) begin
          // Lone left child: one compare, then finish
          mem_we = 1'b1;
          if (cur < mem_rdata) begin
            mem_wdata  = mem_rdata;
            pos_next   = lc_ext[AW-1:0];
            state_next = S_DN_ISSUE;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          mem_raddr  = rc_ext[AW-1:0];
          state_next = S_DN_RIGHT;
        end
      end

      S_DN_RIGHT: begin
        mem_we = 1'b1;
        if (lc_less && rc_less) begin
          state_next = S_DONE;
        end else if (rc_below_lc) begin
          mem_wdata  = left;
          pos_next   = lc_ext[AW-1:0];
          state_next = S_DN_ISSUE;
        end else begin
          // Equal children take the right branch
          mem_wdata  = mem_rdata;
          pos_next   = rc_ext[AW-1:0];
          state_next = S_DN_ISSUE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.top_key   = (count != '0) ? top_ext[KEY_BITS-1:0] : '0;
    res.top_valid = (count != '0);
    res.count     = cnt_ext[COUNT_BITS-1:0];
    res.status    = status;
  end

endmodule

// ===== rtl/mhpq_checker.sv =====
// Port-level assertions for the heap queue, bound to the top level
`timescale 1ns / 1ps
`include "max_heap_priority_queue_unit_defines.svh"

module mhpq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mhpq_pkg::KEY_BITS-1:0]    top_key,
  input logic                             top_valid,
  input logic [mhpq_pkg::COUNT_BITS-1:0]  count,
  input logic [mhpq_pkg::STATUS_BITS-1:0] status
);
  import mhpq_pkg::*;

  `MHPQ_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(top_key) && $stable(top_valid) && $stable(count) && $stable(status), "response changed while stalled")
  `MHPQ_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while a sift is under way")
  `MHPQ_ASSERT_NOW(a_empty_zero, out_valid && !top_valid, count == '0 && top_key == '0, "empty heap reports a key or a count")
  `MHPQ_ASSERT_NOW(a_empty_status, out_valid && status == ST_EMPTY, !top_valid && count == '0, "ignored remove on a non-empty heap")
  `MHPQ_ASSERT_NOW(a_full_status, out_valid && status == ST_FULL, top_valid, "dropped insert on an empty heap")

endmodule

bind max_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .top_key   (rsp.top_key),
  .top_valid (rsp.top_valid),
  .count     (rsp.count),
  .status    (rsp.status)
);
